// File: rtl/core/reversible_double_ended_queue_defines.svh
// Assertion macros shared by the deque RTL.
`ifndef REVERSIBLE_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define REVERSIBLE_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RDQ_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rdq assertion failed");

// Next-cycle implication, disabled while in reset.
`define RDQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rdq assertion failed");

`endif

// File: rtl/core/rdq_pkg.sv
// Shared constants, codes and types for the reversible deque.
package rdq_pkg;

  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CNT_OUT_W = 11;
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [CNT_OUT_W-1:0]     count;
    logic [STAT_W-1:0]        status;
  } out_rsp_t;

  // controller -> datapath strobes
  typedef struct packed {
    logic exec;   // apply the accepted request to pointers and memory
    logic rd;     // read both physical ends
    logic load;   // capture the response into the output register
  } rdq_ctl_t;

endpackage

// File: rtl/core/reversible_double_ended_queue.sv
// Top level of the reversible double-ended queue of signed 32-bit words.
//
// Input channel (in_valid/in_ready/in_data): one request carries a command
// (push front, push back, pop front, pop back, reverse) and a word to push.
// Result channel (out_valid/out_ready/out_data): exactly one response per
// request with the logical front and back words (-1 when empty), the word
// count after the request and a status (ok, underflow, overflow).
// Sequence: the request is applied at its accept edge, both ends are read
// from the 1024-entry ring buffer in the next cycle, and the response is then
// registered into the output register, which waits while that register is full.
// A new request is accepted only after the previous one has gone through the
// write / registered read / response sequence through the single buffer memory.
// Reset (rst_n low, synchronous) empties the queue and clears the reverse
// flag; buffer contents are not cleared, no clearing pass is needed.
// A stalled receiver holds the response in the output register; the next
// request is still accepted and processed, and its response waits until
// the output register drains.
module reversible_double_ended_queue
  import rdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  rdq_ctl_t ctl;

  // sequencer: owns the handshakes and the output-valid flag
  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // storage, pointers and response register
  rdq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/rdq_ctrl.sv
// Sequencer for the deque: accept, read ends, hand off response.
`include "reversible_double_ended_queue_defines.svh"

module rdq_ctrl
  import rdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output rdq_ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.exec  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // output slot free or being drained this cycle
        if (!out_valid_r || out_ready) begin
          ctl.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RDQ_ASSERT_NEXT(a_read_then_load, clk, rst_n, state_r == S_READ, state_r == S_LOAD)
  `RDQ_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, ctl.load, out_valid_r)

endmodule

// File: rtl/core/rdq_datapath.sv
// Ring-buffer storage, end pointers, reverse flag and response register.
`include "reversible_double_ended_queue_defines.svh"

module rdq_datapath
  import rdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rdq_ctl_t ctl,
  input  in_req_t  in_data,
  output out_rsp_t out_data
);

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              rev_r, rev_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [WORD_W-1:0] rd_front_r, rd_back_r;
  out_rsp_t          out_r;

  logic              is_push, is_pop, full, empty, phys_front;
  logic [ADDR_W-1:0] head_prev, head_next, tail_slot, back_slot, wr_addr;
  logic              wr_en;

  // physical slot at offset k from the head, k < DEPTH
  function automatic logic [ADDR_W-1:0] slot_at(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0]  k);
    logic [ADDR_W:0] s;
    s = {1'b0, head} + (ADDR_W+1)'(k);
    if (s >= (ADDR_W+1)'(DEPTH)) begin
      s = s - (ADDR_W+1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  assign is_push = (in_data.command == CMD_PUSH_FRONT) ||
                   (in_data.command == CMD_PUSH_BACK);
  assign is_pop  = (in_data.command == CMD_POP_FRONT) ||
                   (in_data.command == CMD_POP_BACK);
  assign full    = (count_r == DEPTH_CNT);
  assign empty   = (count_r == '0);

  // logical front/back mapped to a physical end through the reverse flag
  assign phys_front = ((in_data.command == CMD_PUSH_FRONT) ||
                       (in_data.command == CMD_POP_FRONT)) ^ rev_r;

  assign head_prev = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_next = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign back_slot = slot_at(head_r, count_r);
  assign tail_slot = slot_at(head_r, count_r - 1'b1);

  assign wr_en   = ctl.exec && is_push && !full;
  assign wr_addr = phys_front ? head_prev : back_slot;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_nxt = ST_OK;
    if (is_push) begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        count_nxt = count_r + 1'b1;
        if (phys_front) begin
          head_nxt = head_prev;
        end
      end
    end else if (is_pop) begin
      if (empty) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        count_nxt = count_r - 1'b1;
        if (phys_front) begin
          head_nxt = head_next;
        end
      end
    end else if (in_data.command == CMD_REVERSE) begin
      rev_nxt = !rev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (ctl.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_r <= status_nxt;
    end
  end

  // storage: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.value;
    end
    if (ctl.rd) begin
      rd_front_r <= mem[head_r];
      rd_back_r  <= mem[tail_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_r.count  <= CNT_OUT_W'(count_r);
      out_r.status <= status_r;
      if (empty) begin
        out_r.front_value <= '1;
        out_r.back_value  <= '1;
      end else begin
        out_r.front_value <= rev_r ? rd_back_r : rd_front_r;
        out_r.back_value  <= rev_r ? rd_front_r : rd_back_r;
      end
    end
  end

  assign out_data = out_r;

  `RDQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_CNT)
  `RDQ_ASSERT_NEXT(a_overflow_holds, clk, rst_n, ctl.exec && is_push && full, $stable(count_r))

endmodule
